[design/omni_drive_mixer_pid_macros.svh]
// Assertion macros shared by the checker of the omni drive mixer.
`ifndef OMNI_DRIVE_MIXER_PID_MACROS_SVH
`define OMNI_DRIVE_MIXER_PID_MACROS_SVH
// Same-cycle implication, sampled on clk and disabled while rst is high.
`define OMDP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk and disabled while rst is high.
`define OMDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[design/omdp_pkg.sv]
// Shared types, constants and the sine table of the omni drive mixer.
package omdp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PID,
    ST_SINE,
    ST_MIX_MUL,
    ST_MIX_DIV_GO,
    ST_MIX_DIV,
    ST_OUT
  } state_t;

  localparam logic [1:0] REG_GAIN_P = 2'd0;
  localparam logic [1:0] REG_GAIN_I = 2'd1;
  localparam logic [1:0] REG_GAIN_D = 2'd2;

  localparam int MulAW = 33;
  localparam int MulBW = 17;
  localparam int MulPW = MulAW + MulBW;

  localparam logic [14:0] QSINE [0:90] = '{
    15'd0, 15'd572, 15'd1144, 15'd1715, 15'd2286, 15'd2856, 15'd3425, 15'd3993,
    15'd4560, 15'd5126, 15'd5690, 15'd6252, 15'd6813, 15'd7371, 15'd7927, 15'd8481,
    15'd9032, 15'd9580, 15'd10126, 15'd10668, 15'd11207, 15'd11743, 15'd12275,
    15'd12803, 15'd13328, 15'd13848, 15'd14365, 15'd14876, 15'd15384, 15'd15886,
    15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324, 15'd18795, 15'd19261,
    15'd19720, 15'd20174, 15'd20622, 15'd21063, 15'd21498, 15'd21926, 15'd22348,
    15'd22763, 15'd23170, 15'd23571, 15'd23965, 15'd24351, 15'd24730, 15'd25102,
    15'd25466, 15'd25822, 15'd26170, 15'd26510, 15'd26842, 15'd27166, 15'd27482,
    15'd27789, 15'd28088, 15'd28378, 15'd28660, 15'd28932, 15'd29197, 15'd29452,
    15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592, 15'd30792, 15'd30983,
    15'd31164, 15'd31336, 15'd31499, 15'd31651, 15'd31795, 15'd31928, 15'd32052,
    15'd32166, 15'd32270, 15'd32365, 15'd32449, 15'd32524, 15'd32589, 15'd32644,
    15'd32688, 15'd32723, 15'd32748, 15'd32763, 15'd32767
  };

endpackage

[design/omdp_ifs.sv]
// Handshake interfaces for command, drive and configuration words.
interface omdp_cmd_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [8:0]  target_angle;
  logic [7:0]  speed;
  logic signed [15:0] heading_error;
  modport source (output valid, operation, target_angle, speed, heading_error,
                  input ready);
  modport sink (input valid, operation, target_angle, speed, heading_error,
                output ready);
endinterface

interface omdp_drive_if;
  logic       valid;
  logic       ready;
  logic [2:0] motor_index;
  logic [7:0] duty;
  logic       forward;
  logic       last;
  modport source (output valid, motor_index, duty, forward, last, input ready);
  modport sink (input valid, motor_index, duty, forward, last, output ready);
endinterface

interface omdp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/omdp_mul.sv]
// Shared signed multiplier with a registered product.
module omdp_mul (
  input  logic clk,
  input  logic signed [omdp_pkg::MulAW-1:0] a,
  input  logic signed [omdp_pkg::MulBW-1:0] b,
  output logic signed [omdp_pkg::MulPW-1:0] prod
);
  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

[design/omdp_div.sv]
// Restoring divider producing an 8-bit quotient, one bit per cycle.
module omdp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [22:0] dividend,
  input  logic [14:0] divisor,
  output logic [7:0]  quotient,
  output logic        done
);
  logic [22:0] rem;
  logic [2:0]  cnt;
  logic        busy;
  logic [22:0] trial;
  logic        fits;

  assign trial = 23'(divisor) << cnt;
  assign fits  = rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= busy && (cnt == 3'd0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd7;
      end else if (busy) begin
        cnt <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      quotient <= 8'd0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - trial;
      end
      quotient <= {quotient[6:0], fits};
    end
  end
endmodule

[design/omni_drive_mixer_pid.sv]
// Top level of the omni drive mixer with PID heading correction.
// One command word updates the PID integral and derivative, then yields one drive
// word per motor in motor order, the final one flagged last. Commands are taken one
// at a time: ready is high only while idle. A command first computes the PID terms
// and the sines, then for each motor in move mode runs one multiply, an 8-step
// restoring divide and presents the word; when the mix term is zero the divide is
// skipped. All products share one multiplier.
module omni_drive_mixer_pid #(
  parameter int MOTORS = 4
) (
  input logic clk,
  input logic rst,
  omdp_cmd_if.sink     cmd,
  omdp_drive_if.source drive,
  omdp_cfg_if.sink     cfg
);
  localparam int IW   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int STEP = 360 / MOTORS;

  omdp_pkg::state_t state, state_next;

  logic signed [15:0] gain_p, gain_i, gain_d;
  logic signed [31:0] error_sum;
  logic signed [15:0] previous_error;
  logic signed [15:0] err;
  logic signed [16:0] deriv;
  logic        align;
  logic [7:0]  speed;
  logic [10:0] target2;
  logic [1:0]  pstep;
  logic signed [49:0] acc;
  logic [IW-1:0] idx;
  logic [10:0] a2;
  logic [14:0] s_abs [MOTORS];
  logic        s_neg [MOTORS];
  logic [14:0] maxabs;
  logic signed [8:0] mix;

  logic signed [omdp_pkg::MulAW-1:0] mul_a;
  logic signed [omdp_pkg::MulBW-1:0] mul_b;
  logic signed [omdp_pkg::MulPW-1:0] prod;
  logic        div_start;
  logic [7:0]  quotient;
  logic        div_done;

  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic [8:0]  tmod;
  logic [10:0] h;
  logic [9:0]  x720;
  logic [8:0]  x360;
  logic [7:0]  xq;
  logic        sneg;
  logic [15:0] pair;
  logic [14:0] sval;
  logic        zero_mix;
  logic        last_motor;
  logic signed [41:0] pid;
  logic signed [42:0] v;
  logic [42:0] vmag;
  logic        cmd_take;
  logic        cfg_take;

  assign cmd_take = cmd.valid && cmd.ready;
  // Gains are written only while idle and no command word is offered.
  assign cfg.ready = (state == omdp_pkg::ST_IDLE) && !cmd.valid;
  assign cfg_take  = cfg.valid && cfg.ready;

  // Integral update with saturation to the 32-bit signed limits.
  always_comb begin
    sum_wide = 33'(error_sum) + 33'(cmd.heading_error);
    if (sum_wide > 33'sh0_7FFF_FFFF) begin
      sum_sat = 32'sh7FFF_FFFF;
    end else if (sum_wide < -33'sh0_8000_0000) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  assign tmod = (cmd.target_angle >= 9'd360) ? cmd.target_angle - 9'd360 : cmd.target_angle;

  // Sine of the current motor's relative angle in half degrees.
  always_comb begin
    h    = target2 + 11'd720 - a2;
    x720 = (h >= 11'd720) ? 10'(h - 11'd720) : h[9:0];
    sneg = x720 >= 10'd360;
    x360 = sneg ? 9'(x720 - 10'd360) : x720[8:0];
    xq   = (x360 > 9'd180) ? 8'(9'd360 - x360) : x360[7:0];
    pair = 16'd0;
    if (xq[0]) begin
      pair = 16'(omdp_pkg::QSINE[xq[7:1]]) + 16'(omdp_pkg::QSINE[xq[7:1] + 7'd1]) + 16'd1;
      sval = pair[15:1];
    end else begin
      sval = omdp_pkg::QSINE[xq[7:1]];
    end
  end

  assign zero_mix   = align || (speed == 8'd0) || (maxabs == 15'd0);
  assign last_motor = idx == IW'(MOTORS - 1);
  assign pid        = acc[49:8];
  assign v          = 43'(mix) - 43'(pid);
  assign vmag       = v[42] ? 43'(-v) : 43'(v);

  assign drive.motor_index = 3'(idx);
  assign drive.duty        = (vmag > 43'd255) ? 8'd255 : vmag[7:0];
  assign drive.forward     = !v[42] && (v != 43'sd0);
  assign drive.last        = last_motor;

  always_comb begin
    state_next = state;
    unique case (state)
      omdp_pkg::ST_IDLE:       if (cmd_take) state_next = omdp_pkg::ST_PID;
      omdp_pkg::ST_PID:        if (pstep == 2'd3) state_next = omdp_pkg::ST_SINE;
      omdp_pkg::ST_SINE:       if (last_motor) state_next = omdp_pkg::ST_MIX_MUL;
      omdp_pkg::ST_MIX_MUL:    state_next = zero_mix ? omdp_pkg::ST_OUT
                                                     : omdp_pkg::ST_MIX_DIV_GO;
      omdp_pkg::ST_MIX_DIV_GO: state_next = omdp_pkg::ST_MIX_DIV;
      omdp_pkg::ST_MIX_DIV:    if (div_done) state_next = omdp_pkg::ST_OUT;
      omdp_pkg::ST_OUT: begin
        if (drive.ready) begin
          state_next = last_motor ? omdp_pkg::ST_IDLE : omdp_pkg::ST_MIX_MUL;
        end
      end
      default:                 state_next = omdp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready   = 1'b0;
    drive.valid = 1'b0;
    div_start   = 1'b0;
    mul_a       = 33'(err);
    mul_b       = 17'(gain_p);
    unique case (state)
      omdp_pkg::ST_IDLE: cmd.ready = 1'b1;
      omdp_pkg::ST_PID: begin
        case (pstep)
          2'd1: begin
            mul_a = 33'(error_sum);
            mul_b = 17'(gain_i);
          end
          2'd2: begin
            mul_a = 33'(deriv);
            mul_b = 17'(gain_d);
          end
          default: begin
            mul_a = 33'(err);
            mul_b = 17'(gain_p);
          end
        endcase
      end
      omdp_pkg::ST_MIX_MUL: begin
        mul_a = $signed({18'd0, s_abs[idx]});
        mul_b = $signed({9'd0, speed});
      end
      omdp_pkg::ST_MIX_DIV_GO: div_start = 1'b1;
      omdp_pkg::ST_OUT: drive.valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= omdp_pkg::ST_IDLE;
      gain_p         <= 16'sd0;
      gain_i         <= 16'sd0;
      gain_d         <= 16'sd0;
      error_sum      <= 32'sd0;
      previous_error <= 16'sd0;
    end else begin
      state <= state_next;
      if (cfg_take) begin
        unique case (cfg.index)
          omdp_pkg::REG_GAIN_P: begin
            gain_p         <= cfg.data;
            error_sum      <= 32'sd0;
            previous_error <= 16'sd0;
          end
          omdp_pkg::REG_GAIN_I: gain_i <= cfg.data;
          omdp_pkg::REG_GAIN_D: gain_d <= cfg.data;
          default: begin
          end
        endcase
      end else if (cmd_take) begin
        error_sum      <= sum_sat;
        previous_error <= cmd.heading_error;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      omdp_pkg::ST_IDLE: begin
        err     <= cmd.heading_error;
        deriv   <= 17'(cmd.heading_error) - 17'(previous_error);
        align   <= cmd.operation;
        speed   <= cmd.speed;
        target2 <= {1'b0, tmod, 1'b0};
        pstep   <= 2'd0;
      end
      omdp_pkg::ST_PID: begin
        pstep <= pstep + 2'd1;
        if (pstep == 2'd1) begin
          acc <= 50'(prod);
        end else if (pstep != 2'd0) begin
          acc <= acc + 50'(prod);
        end
        idx    <= '0;
        a2     <= 11'(STEP);
        maxabs <= 15'd0;
      end
      omdp_pkg::ST_SINE: begin
        s_abs[idx] <= sval;
        s_neg[idx] <= sneg && (sval != 15'd0);
        if (sval > maxabs) begin
          maxabs <= sval;
        end
        a2  <= a2 + 11'(2 * STEP);
        idx <= last_motor ? '0 : idx + IW'(1);
      end
      omdp_pkg::ST_MIX_MUL: begin
        if (zero_mix) begin
          mix <= 9'sd0;
        end
      end
      omdp_pkg::ST_MIX_DIV: begin
        if (div_done) begin
          mix <= s_neg[idx] ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
        end
      end
      omdp_pkg::ST_OUT: begin
        if (drive.ready && !last_motor) begin
          idx <= idx + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  omdp_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  omdp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[22:0]),
    .divisor  (maxabs),
    .quotient (quotient),
    .done     (div_done)
  );
endmodule

[design/omdp_checker.sv]
// Port-level checker for the omni drive mixer, bound to the top level.
`include "omni_drive_mixer_pid_macros.svh"
module omdp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] duty,
  input logic       forward,
  input logic       last
);
  // A command word occupies the block until its last drive word leaves.
  `OMDP_ASSERT_NEXT(a_busy_after_cmd, in_valid && in_ready, !in_ready, "ready after accept")
  `OMDP_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready, "ready while drive word pending")
  `OMDP_ASSERT_NEXT(a_idle_after_last, out_valid && out_ready && last, in_ready, "not idle")
  `OMDP_ASSERT_IMPL(a_dir_duty, out_valid && forward, duty != 8'd0, "forward with zero duty")
  `OMDP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(duty), "word dropped")
endmodule

bind omni_drive_mixer_pid omdp_checker u_omdp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd.valid),
  .in_ready  (cmd.ready),
  .out_valid (drive.valid),
  .out_ready (drive.ready),
  .duty      (drive.duty),
  .forward   (drive.forward),
  .last      (drive.last)
);

[test/omdp_drive_checker.sv]
// Checker for the omni drive mixer: predicts drive words and compares them.
module omdp_drive_checker #(
  parameter int MOTORS = 4
) (
  input  logic clk,
  input  logic rst,
  omdp_cmd_if.sink     cmd,
  omdp_drive_if.sink   drive,
  omdp_cfg_if.sink     cfg,
  output int           fail_count,
  output int           pending
);
  typedef struct packed {
    logic [2:0] motor_index;
    logic [7:0] duty;
    logic       forward;
    logic       last;
  } drive_word_t;

  drive_word_t expected_drive[$];
  logic signed [15:0] kp, ki, kd;
  logic signed [31:0] err_sum;
  logic signed [15:0] prev_err;

  // Sine of an angle in half degrees, Q1.15.
  function automatic int half_deg_sine(int h);
    int x;
    int k;
    int val;
    bit neg;
    x = h % 720;
    neg = 0;
    if (x >= 360) begin
      x -= 360;
      neg = 1;
    end
    if (x > 180) x = 360 - x;
    k = x >> 1;
    if (x % 2 == 1) begin
      val = (int'(omdp_pkg::QSINE[k]) + int'(omdp_pkg::QSINE[k + 1]) + 1) >>> 1;
    end else begin
      val = int'(omdp_pkg::QSINE[k]);
    end
    return neg ? -val : val;
  endfunction

  task automatic predict_drive(logic op, logic [8:0] ang, logic [7:0] spd,
                               logic signed [15:0] e);
    longint sum;
    longint deriv;
    longint acc;
    longint pid;
    longint maxabs;
    longint mix;
    longint v;
    longint mag;
    int s[MOTORS];
    int t2;
    int a2;
    drive_word_t w;
    sum = longint'(err_sum) + e;
    deriv = longint'(e) - prev_err;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    err_sum = sum[31:0];
    prev_err = e;
    acc = longint'(e) * kp + sum * ki + deriv * kd;
    pid = acc >>> 8;
    t2 = (int'(ang) % 360) * 2;
    maxabs = 0;
    for (int i = 0; i < MOTORS; i++) begin
      a2 = ((360 / MOTORS) * (2 * i + 1)) % 720;
      s[i] = half_deg_sine(t2 + 720 - a2);
      if ((s[i] < 0 ? -s[i] : s[i]) > maxabs) maxabs = s[i] < 0 ? -s[i] : s[i];
    end
    for (int i = 0; i < MOTORS; i++) begin
      mix = 0;
      if (!op && spd != 0 && maxabs != 0) begin
        mix = (longint'(s[i] < 0 ? -s[i] : s[i]) * spd) / maxabs;
        if (s[i] < 0) mix = -mix;
      end
      v = mix - pid;
      mag = v < 0 ? -v : v;
      if (mag > 255) mag = 255;
      w.motor_index = i[2:0];
      w.duty = mag[7:0];
      w.forward = v > 0;
      w.last = (i == MOTORS - 1);
      expected_drive.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    drive_word_t got;
    drive_word_t want;
    if (rst) begin
      kp = 0;
      ki = 0;
      kd = 0;
      err_sum = 0;
      prev_err = 0;
      fail_count = 0;
      expected_drive.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          omdp_pkg::REG_GAIN_P: begin
            kp = cfg.data;
            err_sum = 0;
            prev_err = 0;
          end
          omdp_pkg::REG_GAIN_I: ki = cfg.data;
          omdp_pkg::REG_GAIN_D: kd = cfg.data;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready)
        predict_drive(cmd.operation, cmd.target_angle, cmd.speed, cmd.heading_error);
      if (drive.valid && drive.ready) begin
        got = {drive.motor_index, drive.duty, drive.forward, drive.last};
        if (expected_drive.size() == 0) begin
          if (fail_count < 10) $display("unexpected drive word %p", got);
          fail_count = fail_count + 1;
        end else begin
          want = expected_drive.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("drive mismatch: expected %p, got %p", want, got);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending = expected_drive.size();
  end
endmodule

[test/tb_omni_drive_mixer_pid.sv]
// Testbench top for the omni drive mixer: stimulus, stalls and verdict.
module tb_omni_drive_mixer_pid;
  localparam int MOTORS = 4;
  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   timed_out;
  int   stall_phase;

  omdp_cmd_if   cmd ();
  omdp_drive_if drive ();
  omdp_cfg_if   cfg ();

  omni_drive_mixer_pid #(.MOTORS(MOTORS)) dut (
    .clk(clk), .rst(rst), .cmd(cmd), .drive(drive), .cfg(cfg)
  );

  omdp_drive_checker #(.MOTORS(MOTORS)) checker_i (
    .clk(clk), .rst(rst), .cmd(cmd), .drive(drive), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The receiver cycles through stall-free stretches, light stalling and heavy stalling.
  always @(posedge clk) begin
    if (rst) begin
      drive.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 400;
      if (stall_phase < 100) drive.ready <= 1'b1;
      else if (stall_phase < 250) drive.ready <= ($urandom_range(3) != 0);
      else drive.ready <= ($urandom_range(3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst) idle_cycles <= 0;
    else if ((cmd.valid && cmd.ready) || (drive.valid && drive.ready) ||
             (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_cmd(logic op, logic [8:0] ang, logic [7:0] spd, logic [15:0] e);
    cmd.valid <= 1'b1;
    cmd.operation <= op;
    cmd.target_angle <= ang;
    cmd.speed <= spd;
    cmd.heading_error <= e;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic pause_cmd(int n);
    cmd.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_gain(logic [1:0] idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain_and_settle();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_gains(int pick);
    logic [15:0] g[3];
    for (int r = 0; r < 3; r++) begin
      case (pick)
        0: g[r] = 16'h7fff;
        1: g[r] = 16'h8000;
        default: g[r] = ($urandom_range(3) == 0) ? 16'($urandom) :
                        16'($signed($urandom_range(1024)) - 512);
      endcase
    end
    write_gain(omdp_pkg::REG_GAIN_P, g[0]);
    write_gain(omdp_pkg::REG_GAIN_I, g[1]);
    write_gain(omdp_pkg::REG_GAIN_D, g[2]);
  endtask

  task automatic random_cmd();
    logic [8:0] ang;
    logic [15:0] e;
    ang = ($urandom_range(15) == 0) ? 9'($urandom_range(511, 360)) : 9'($urandom_range(359));
    case ($urandom_range(4))
      0: e = 16'($urandom);
      1: e = $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: e = 16'($signed($urandom_range(200)) - 100);
    endcase
    send_cmd($urandom_range(4) == 0, ang, ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom), e);
  endtask

  initial begin
    rst = 1'b1;
    timed_out = 0;
    cmd.valid = 1'b0;
    cmd.operation = 1'b0;
    cmd.target_angle = '0;
    cmd.speed = '0;
    cmd.heading_error = '0;
    cfg.valid = 1'b0;
    cfg.index = omdp_pkg::REG_GAIN_P;
    cfg.data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero gains: pure mixing, angle extremes, zero speed, out-of-range angle, align mode.
    send_cmd(1'b0, 9'd0, 8'd255, 16'h0000);
    send_cmd(1'b0, 9'd359, 8'd255, 16'h0000);
    send_cmd(1'b0, 9'd45, 8'd200, 16'h0000);
    send_cmd(1'b0, 9'd90, 8'd0, 16'h0000);
    send_cmd(1'b0, 9'd511, 8'd128, 16'h0000);
    send_cmd(1'b0, 9'd360, 8'd1, 16'h0000);
    send_cmd(1'b1, 9'd180, 8'd255, 16'h7fff);
    drain_and_settle();

    // Maximum and minimum gains, with heading errors at both extremes.
    random_gains(0);
    for (int n = 0; n < 6; n++) send_cmd(1'b0, 9'd270, 8'd255, 16'h7fff);
    for (int n = 0; n < 6; n++) send_cmd(1'b1, 9'd0, 8'd0, 16'h8000);
    drain_and_settle();
    random_gains(1);
    send_cmd(1'b0, 9'd135, 8'd100, 16'h8000);
    send_cmd(1'b0, 9'd225, 8'd100, 16'h7fff);
    send_cmd(1'b1, 9'd10, 8'd7, 16'hffff);
    send_cmd(1'b0, 9'd300, 8'd50, 16'h0001);
    drain_and_settle();

    for (int ph = 0; ph < 6; ph++) begin
      random_gains(2);
      for (int n = 0; n < 58; n++) begin
        random_cmd();
        if ($urandom_range(2) == 0) pause_cmd($urandom_range(40));
      end
      drain_and_settle();
    end

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
